>>> hw/rtl/nsd_pkg.sv
// ============================================================================
// nsd_pkg : shared types and constants for the second derivative block
// Stencil geometry, field widths and the sideband that travels with a beat.
// ============================================================================
package nsd_pkg;

    localparam int NPT   = 5;           // stencil points
    localparam int NOTH  = NPT - 1;     // other points seen from one point
    localparam int NPR   = 10;          // unordered point pairs
    localparam int PW    = 32;          // position / value width
    localparam int IN_W  = 2 * NPT * PW;
    localparam int OW    = 48;          // result width
    localparam int ORD_W = 3;

    localparam logic [ORD_W-1:0] ORD_RST = 3'd2;
    localparam logic [ORD_W-1:0] ORD_MIN = 3'd2;
    localparam logic [ORD_W-1:0] ORD_MAX = 3'd4;

    // control that follows a beat down the pipe
    typedef struct packed {
        logic            valid;
        logic            zero;      // order below two
        logic            fault;     // coinciding used positions
        logic [NPT-1:0]  used;      // point takes part
        logic [NPT-1:0]  neg;       // sign of each term
    } t_side;

    // k-th other point of point i, in ascending order
    function automatic int other_idx(input int i, input int k);
        return (k < i) ? k : k + 1;
    endfunction

    // lower point of pair p
    function automatic int pair_lo(input int p);
        int r;
        r = 0;
        unique case (p)
            0, 1, 2, 3: r = 0;
            4, 5, 6:    r = 1;
            7, 8:       r = 2;
            9:          r = 3;
            default:    r = 0;
        endcase
        return r;
    endfunction

    // upper point of pair p
    function automatic int pair_hi(input int p);
        int r;
        r = 1;
        unique case (p)
            0:          r = 1;
            1, 4:       r = 2;
            2, 5, 7:    r = 3;
            3, 6, 8, 9: r = 4;
            default:    r = 1;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/nsd_div.sv
// ============================================================================
// nsd_div : pipelined unsigned restoring divider
// One quotient bit per register stage, NW stages, a new operand pair per beat.
// ============================================================================
module nsd_div #(
    parameter int NW = 130,
    parameter int DW = 129
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_num;
        logic [NW-1:0] n_quo;
        logic [DW-1:0] n_den;
        logic [DW:0]   trial;
        logic          ge;

        // stage input: operands at the head, previous stage elsewhere
        if (s == 0) begin : g_head
            assign n_rem = '0;
            assign n_num = i_num;
            assign n_quo = '0;
            assign n_den = i_den;
        end else begin : g_body
            assign n_rem = r_rem[s-1];
            assign n_num = r_num[s-1];
            assign n_quo = r_quo[s-1];
            assign n_den = r_den[s-1];
        end

        // bring down one numerator bit and try the subtraction
        assign trial = {n_rem, n_num[NW-1]};
        assign ge    = (trial >= {1'b0, n_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? DW'(trial - {1'b0, n_den}) : trial[DW-1:0];
                r_num[s] <= {n_num[NW-2:0], 1'b0};
                r_quo[s] <= {n_quo[NW-2:0], ge};
                r_den[s] <= n_den;
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

>>> hw/rtl/nonuniform_second_derivative.sv
// ============================================================================
// nonuniform_second_derivative : second derivative from a nonuniform stencil
// Lagrange weights over order+1 points, one rounded term per point, saturated.
// ============================================================================
// Usage
//   Input beat on the s-side: positions and values of five points, signed
//   fixed point with FRAC_BITS fraction bits. Output beat on the m-side: the
//   48-bit saturated second derivative in tdata, the coincidence fault in tuser.
//   The order register is written through i_cfg_we / i_cfg_wdata by the user,
//   only while no beat is in flight; the block itself does not enforce this.
//   Order values 5..7 act as 4, 0 and 1 give a zero result.
// Throughput: one beat per cycle, sustained while the output is not held.
// Pipe: stages A to G, the divider, H, I, J. The divider sets the depth; it
//   resolves one of its NW = max(98 + 2*FRAC_BITS, 128) + 1 bits per stage.
// Reset: synchronous, active low; empties the pipe and sets the order to two.
// Stall: when the output is held and not taken, the whole pipe freezes and
//   o_s_tready drops in the same cycle; nothing is lost or repeated.
// ============================================================================
module nonuniform_second_derivative #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // pos_a, pos_b, pos_c, pos_d, pos_e, val_a, val_b, val_c, val_d, val_e
    input  logic [nsd_pkg::IN_W-1:0]     i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // second_deriv
    output logic [nsd_pkg::OW-1:0]       o_m_tdata,
    // divide_fault
    output logic                         o_m_tuser,
    input  logic                         i_cfg_we,
    input  logic [nsd_pkg::ORD_W-1:0]    i_cfg_wdata
);

    import nsd_pkg::*;

    localparam int SH = 2 * FRAC_BITS + 2;
    localparam int NW = (((98 + 2 * FRAC_BITS) > 128) ? (98 + 2 * FRAC_BITS) : 128) + 1;
    localparam int DW = 129;
    localparam int SW = NW + 3;

    logic adv;

    logic [ORD_W-1:0] r_order;

    // stage A: capture
    t_side                   r_a_side;
    logic signed [PW-1:0]    r_a_x [NPT];
    logic signed [PW-1:0]    r_a_v [NPT];
    logic [ORD_W-1:0]        r_a_ord;
    t_side                   n_a_side;
    logic [ORD_W-1:0]        n_a_ord;

    // stage B: differences, pair products, fault
    t_side                   r_b_side;
    logic signed [PW:0]      r_b_d  [NPT][NOTH];
    logic signed [2*PW-1:0]  r_b_pp [NPR];
    logic signed [PW-1:0]    r_b_x  [NPT];
    logic signed [PW-1:0]    r_b_v  [NPT];
    logic [ORD_W-1:0]        r_b_ord;
    logic signed [PW:0]      n_b_d  [NPT][NOTH];
    logic signed [2*PW-1:0]  n_b_pp [NPR];
    logic                    n_b_fault;
    t_side                   n_b_side;

    // stage C: factor magnitudes, symmetric sums
    t_side                   r_c_side;
    logic [PW-1:0]           r_c_fm   [NPT][NOTH];
    logic [NOTH-1:0]         r_c_fneg [NPT];
    logic signed [65:0]      r_c_e    [NPT];
    logic signed [PW-1:0]    r_c_v    [NPT];
    logic [ORD_W-1:0]        r_c_ord;
    logic [PW-1:0]           n_c_fm   [NPT][NOTH];
    logic [NOTH-1:0]         n_c_fneg [NPT];
    logic signed [65:0]      n_c_e    [NPT];

    // stage D: half products of the denominator, magnitudes
    t_side                   r_d_side;
    logic [63:0]             r_d_p01  [NPT];
    logic [63:0]             r_d_p23  [NPT];
    logic [64:0]             r_d_emag [NPT];
    logic [PW-1:0]           r_d_vmag [NPT];
    logic [63:0]             n_d_p01  [NPT];
    logic [63:0]             n_d_p23  [NPT];
    logic [64:0]             n_d_emag [NPT];
    logic [PW-1:0]           n_d_vmag [NPT];
    logic [NPT-1:0]          n_d_neg;
    t_side                   n_d_side;

    // stage E: partial products
    t_side                   r_e_side;
    logic [63:0]             r_e_ll  [NPT];
    logic [63:0]             r_e_lh  [NPT];
    logic [63:0]             r_e_hl  [NPT];
    logic [63:0]             r_e_hh  [NPT];
    logic [63:0]             r_e_evl [NPT];
    logic [64:0]             r_e_evh [NPT];

    // stage F: full denominator and numerator magnitudes
    t_side                   r_f_side;
    logic [127:0]            r_f_den [NPT];
    logic [95:0]             r_f_evm [NPT];

    // stage G: divider operands
    t_side                   r_g_side;
    logic [NW-1:0]           r_g_num [NPT];
    logic [DW-1:0]           r_g_dv  [NPT];

    // sideband alongside the divider
    t_side                   r_dl [NW];
    logic [NW-1:0]           quo  [NPT];

    // stage H: signed terms
    t_side                   r_h_side;
    logic signed [NW-1:0]    r_h_term [NPT];
    logic signed [NW-1:0]    n_h_term [NPT];

    // stage I: sum
    t_side                   r_i_side;
    logic signed [SW-1:0]    r_i_sum;
    logic signed [SW-1:0]    n_i_sum;

    // stage J: output register
    t_side                   r_j_side;
    logic [OW-1:0]           r_j_data;
    logic [OW-1:0]           n_j_data;

    // whole pipe moves unless the output beat is held
    assign adv        = !r_j_side.valid || i_m_tready;
    assign o_s_tready = adv;

    // order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_RST;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // stage A control
    always_comb begin
        n_a_ord        = (r_order > ORD_MAX) ? ORD_MAX : r_order;
        n_a_side       = '0;
        n_a_side.valid = i_s_tvalid;
        n_a_side.zero  = (n_a_ord < ORD_MIN);
        for (int i = 0; i < NPT; i++) begin
            n_a_side.used[i] = (ORD_W'(i) <= n_a_ord);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NPT; i++) begin
                r_a_x[i] <= i_s_tdata[PW*i +: PW];
                r_a_v[i] <= i_s_tdata[PW*(NPT+i) +: PW];
            end
            r_a_ord <= n_a_ord;
        end
    end

    // stage B: differences to the other points, pair products, coincidence
    always_comb begin
        n_b_fault = 1'b0;
        for (int i = 0; i < NPT; i++) begin
            for (int k = 0; k < NOTH; k++) begin
                n_b_d[i][k] = (PW+1)'(r_a_x[i]) - (PW+1)'(r_a_x[other_idx(i, k)]);
            end
        end
        for (int p = 0; p < NPR; p++) begin
            n_b_pp[p] = r_a_x[pair_lo(p)] * r_a_x[pair_hi(p)];
            if ((ORD_W'(pair_hi(p)) <= r_a_ord) &&
                (r_a_x[pair_lo(p)] == r_a_x[pair_hi(p)])) begin
                n_b_fault = 1'b1;
            end
        end
        n_b_side       = r_a_side;
        n_b_side.fault = n_b_fault && !r_a_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_d   <= n_b_d;
            r_b_pp  <= n_b_pp;
            r_b_x   <= r_a_x;
            r_b_v   <= r_a_v;
            r_b_ord <= r_a_ord;
        end
    end

    // stage C: factor magnitudes (unused factors are one), symmetric sums
    always_comb begin
        for (int i = 0; i < NPT; i++) begin
            for (int k = 0; k < NOTH; k++) begin
                if (ORD_W'(k) < r_b_ord) begin
                    n_c_fm[i][k]   = r_b_d[i][k][PW] ? PW'(~r_b_d[i][k] + 33'd1)
                                                     : r_b_d[i][k][PW-1:0];
                    n_c_fneg[i][k] = r_b_d[i][k][PW];
                end else begin
                    n_c_fm[i][k]   = PW'(1);
                    n_c_fneg[i][k] = 1'b0;
                end
            end
            n_c_e[i] = '0;
            if (r_b_ord == 3'd2) begin
                n_c_e[i] = 66'sd1;
            end else if (r_b_ord == 3'd3) begin
                for (int k = 0; k < 3; k++) begin
                    n_c_e[i] = n_c_e[i] + 66'(r_b_x[other_idx(i, k)]);
                end
            end else if (r_b_ord == ORD_MAX) begin
                for (int p = 0; p < NPR; p++) begin
                    if (pair_lo(p) != i && pair_hi(p) != i) begin
                        n_c_e[i] = n_c_e[i] + 66'(r_b_pp[p]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_fm   <= n_c_fm;
            r_c_fneg <= n_c_fneg;
            r_c_e    <= n_c_e;
            r_c_v    <= r_b_v;
            r_c_ord  <= r_b_ord;
        end
    end

    // stage D: pairs of factors, magnitudes and term signs
    always_comb begin
        for (int i = 0; i < NPT; i++) begin
            n_d_p01[i]  = 64'(r_c_fm[i][0]) * 64'(r_c_fm[i][1]);
            n_d_p23[i]  = 64'(r_c_fm[i][2]) * 64'(r_c_fm[i][3]);
            n_d_emag[i] = r_c_e[i][65] ? 65'(~r_c_e[i] + 66'd1) : r_c_e[i][64:0];
            n_d_vmag[i] = r_c_v[i][PW-1] ? (~r_c_v[i] + 32'd1) : r_c_v[i];
            n_d_neg[i]  = (^r_c_fneg[i]) ^ r_c_e[i][65] ^ r_c_v[i][PW-1] ^ r_c_ord[0];
        end
        n_d_side     = r_c_side;
        n_d_side.neg = n_d_neg;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_p01  <= n_d_p01;
            r_d_p23  <= n_d_p23;
            r_d_emag <= n_d_emag;
            r_d_vmag <= n_d_vmag;
        end
    end

    // stage E: 32-bit partial products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NPT; i++) begin
                r_e_ll[i]  <= 64'(r_d_p01[i][31:0])  * 64'(r_d_p23[i][31:0]);
                r_e_lh[i]  <= 64'(r_d_p01[i][31:0])  * 64'(r_d_p23[i][63:32]);
                r_e_hl[i]  <= 64'(r_d_p01[i][63:32]) * 64'(r_d_p23[i][31:0]);
                r_e_hh[i]  <= 64'(r_d_p01[i][63:32]) * 64'(r_d_p23[i][63:32]);
                r_e_evl[i] <= 64'(r_d_emag[i][31:0]) * 64'(r_d_vmag[i]);
                r_e_evh[i] <= 65'(r_d_emag[i][64:32]) * 65'(r_d_vmag[i]);
            end
        end
    end

    // stage F: assemble products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NPT; i++) begin
                r_f_den[i] <= 128'(r_e_ll[i]) + (128'(r_e_lh[i]) << 32)
                            + (128'(r_e_hl[i]) << 32) + (128'(r_e_hh[i]) << 64);
                r_f_evm[i] <= 96'(r_e_evl[i]) + (96'(r_e_evh[i]) << 32);
            end
        end
    end

    // stage G: rounding numerator 2|N|+|D| over 2|D|
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NPT; i++) begin
                r_g_num[i] <= (NW'(r_f_evm[i]) << SH) + NW'(r_f_den[i]);
                r_g_dv[i]  <= {r_f_den[i], 1'b0};
            end
        end
    end

    // one divider per point
    for (genvar i = 0; i < NPT; i++) begin : g_div
        nsd_div #(
            .NW (NW),
            .DW (DW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_g_num[i]),
            .i_den (r_g_dv[i]),
            .o_quo (quo[i])
        );
    end

    // stage H: apply sign, drop unused terms
    always_comb begin
        for (int i = 0; i < NPT; i++) begin
            if (r_dl[NW-1].used[i] && !r_dl[NW-1].zero && !r_dl[NW-1].fault) begin
                n_h_term[i] = r_dl[NW-1].neg[i] ? NW'(-quo[i]) : quo[i];
            end else begin
                n_h_term[i] = '0;
            end
        end
    end

    // stage I: exact sum
    always_comb begin
        n_i_sum = '0;
        for (int i = 0; i < NPT; i++) begin
            n_i_sum = n_i_sum + SW'(r_h_term[i]);
        end
    end

    // stage J: saturate to 48 bits
    always_comb begin
        if (r_i_side.zero || r_i_side.fault) begin
            n_j_data = '0;
        end else if (!r_i_sum[SW-1] && (|r_i_sum[SW-2:OW-1])) begin
            n_j_data = {1'b0, {(OW-1){1'b1}}};
        end else if (r_i_sum[SW-1] && !(&r_i_sum[SW-2:OW-1])) begin
            n_j_data = {1'b1, {(OW-1){1'b0}}};
        end else begin
            n_j_data = r_i_sum[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_term <= n_h_term;
            r_i_sum  <= n_i_sum;
            r_j_data <= n_j_data;
        end
    end

    // sideband through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
            r_d_side <= '0;
            r_e_side <= '0;
            r_f_side <= '0;
            r_g_side <= '0;
            for (int s = 0; s < NW; s++) begin
                r_dl[s] <= '0;
            end
            r_h_side <= '0;
            r_i_side <= '0;
            r_j_side <= '0;
        end else if (adv) begin
            r_a_side       <= n_a_side;
            r_b_side       <= n_b_side;
            r_c_side       <= r_b_side;
            r_d_side       <= n_d_side;
            r_e_side       <= r_d_side;
            r_f_side       <= r_e_side;
            r_g_side       <= r_f_side;
            r_dl[0]        <= r_g_side;
            for (int s = 1; s < NW; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
            r_h_side <= r_dl[NW-1];
            r_i_side <= r_h_side;
            r_j_side <= r_i_side;
        end
    end

    assign o_m_tvalid = r_j_side.valid;
    assign o_m_tdata  = r_j_data;
    assign o_m_tuser  = r_j_side.fault;

endmodule

>>> hw/rtl/nsd_chk.sv
// ============================================================================
// nsd_chk : port-level checks for the second derivative block
// Watches both stream sides.
// ============================================================================
module nsd_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [nsd_pkg::OW-1:0]    o_m_tdata,
    input logic                      o_m_tuser
);

    // held beat keeps its payload
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // input side is open exactly when the pipe can move
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    // a fault beat carries a zero result
    a_fault : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("fault beat with nonzero result");

    // pipe is empty right after reset
    a_rst : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind nonuniform_second_derivative nsd_chk u_nsd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

>>> tb/nsd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// nsd_checker : result predictor and scoreboard for the second derivative
// Watches the input, output and order-register ports, works out the expected
// derivative and fault for every accepted stencil beat, and compares them in
// order with the beats that leave the block.
// ============================================================================
module nsd_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [nsd_pkg::IN_W-1:0]     i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [nsd_pkg::OW-1:0]       i_m_tdata,
    input  logic                         i_m_tuser,
    input  logic                         i_cfg_we,
    input  logic [nsd_pkg::ORD_W-1:0]    i_cfg_wdata,
    output int                           o_pending,
    output int                           o_fail_count,
    output int                           o_result_count,
    output int                           o_fault_count
);
    import nsd_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [OW-1:0] deriv;
        logic          fault;
    } t_deriv;

    logic [ORD_W-1:0] order_q;
    t_deriv           deriv_queue[$];

    // Lagrange second derivative at zero, one rounded term per point
    function automatic t_deriv predict_deriv(input logic [IN_W-1:0] stencil,
                                             input logic [ORD_W-1:0] ord);
        t_deriv r;
        int     n;
        int     np;
        t_wide  x[NPT];
        t_wide  v[NPT];
        t_wide  e, den, num, an, ad, q, acc;
        logic   neg;
        r   = '0;
        acc = 0;
        n   = (ord > ORD_MAX) ? int'(ORD_MAX) : int'(ord);
        if (n < 2) return r;
        np = n + 1;
        for (int i = 0; i < NPT; i++) begin
            x[i] = $signed(stencil[PW*i +: PW]);
            v[i] = $signed(stencil[PW*(NPT+i) +: PW]);
        end
        // coinciding used positions: fault, zero result
        for (int i = 0; i < np; i++)
            for (int j = i + 1; j < np; j++)
                if (x[i] == x[j]) begin
                    r.fault = 1'b1;
                    return r;
                end
        for (int i = 0; i < np; i++) begin
            e   = 0;
            den = 1;
            if (n == 2) e = 1;
            for (int j = 0; j < np; j++) begin
                if (j == i) continue;
                den = den * (x[i] - x[j]);
                if (n == 3) e = e + x[j];
                if (n == 4)
                    for (int k = j + 1; k < np; k++)
                        if (k != i) e = e + x[j] * x[k];
            end
            num = e * v[i];
            if (n % 2 == 1) num = -num;
            num = num <<< (2 * FRAC_BITS + 1);
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            // ties away from zero
            q   = (2 * an + ad) / (2 * ad);
            acc = neg ? acc - q : acc + q;
        end
        if (acc < -(t_wide'(1) <<< 47)) acc = -(t_wide'(1) <<< 47);
        if (acc > (t_wide'(1) <<< 47) - 1) acc = (t_wide'(1) <<< 47) - 1;
        r.deriv = acc[OW-1:0];
        return r;
    endfunction

    assign o_pending = deriv_queue.size();

    // scoreboard: compare leaving beats first, then queue the new prediction
    always @(posedge i_clk) begin
        t_deriv want;
        if (!i_rst_n) begin
            order_q        <= ORD_RST;
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_fault_count  <= 0;
            deriv_queue.delete();
        end else begin
            if (i_cfg_we) order_q <= i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                o_result_count <= o_result_count + 1;
                if (i_m_tuser) o_fault_count <= o_fault_count + 1;
                if (deriv_queue.size() == 0) begin
                    $display("%0t: unexpected beat deriv=%h fault=%b",
                             $time, i_m_tdata, i_m_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = deriv_queue.pop_front();
                    if (want.deriv !== i_m_tdata || want.fault !== i_m_tuser) begin
                        $display("%0t: mismatch expected deriv=%h fault=%b, got deriv=%h fault=%b",
                                 $time, want.deriv, want.fault, i_m_tdata, i_m_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                deriv_queue.push_back(predict_deriv(i_s_tdata, order_q));
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench : stimulus and verdict for the second derivative block
// Drives directed and random stencils through every order setting with random
// idling on both sides; the checker beside the block scores the results.
// ============================================================================
module testbench;
    import nsd_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = 160;
    localparam int WDOG_LIMIT = 6000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OW-1:0]       m_tdata;
    logic                m_tuser;
    logic                cfg_we;
    logic [ORD_W-1:0]    cfg_wdata;

    int   pending, fail_count, result_count, fault_count;
    int   sent_count;
    int   idle_cnt = 0;
    logic idle_on;

    nonuniform_second_derivative #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    nsd_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_fault_count  (fault_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sink side: random back-pressure
    always @(posedge i_clk)
        m_tready <= (idle_on && $urandom_range(99) < 34) ? 1'b0 : 1'b1;

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_stencil(input logic [PW-1:0] p[NPT],
                                                     input logic [PW-1:0] v[NPT]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < NPT; i++) begin
            d[PW*i +: PW]       = p[i];
            d[PW*(NPT+i) +: PW] = v[i];
        end
        return d;
    endfunction

    // one stencil beat, with random gaps ahead of it
    task automatic send_stencil(input logic [IN_W-1:0] d);
        while (idle_on && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // write the order register once the pipe has drained
    task automatic set_order(input logic [ORD_W-1:0] ord);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ord;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // random stencil: mostly well-spread grids, some wide, some coinciding
    task automatic send_random;
        logic [PW-1:0] p[NPT];
        logic [PW-1:0] v[NPT];
        int            mode, h, a, b;
        mode = $urandom_range(99);
        h    = $urandom_range(1 << 18, 1 << 10);
        for (int i = 0; i < NPT; i++) begin
            p[i] = (i - 2) * h + $urandom_range(h / 4);
            v[i] = $signed($urandom()) >>> $urandom_range(12, 0);
        end
        if (mode < 20) begin
            for (int i = 0; i < NPT; i++) p[i] = $urandom();
        end else if (mode < 32) begin
            a = $urandom_range(NPT - 1);
            b = $urandom_range(NPT - 1);
            p[a] = p[b];
        end else if (mode < 40) begin
            for (int i = 0; i < NPT; i++)
                p[i] = $urandom_range(1) ? 32'h8000_0000 + i : 32'h7FFF_FFFF - i;
            for (int i = 0; i < NPT; i++) v[i] = $urandom();
        end else if (mode < 46) begin
            for (int i = 0; i < NPT; i++) p[i] = (i - 2) * $urandom_range(3, 1);
        end
        send_stencil(pack_stencil(p, v));
    endtask

    task automatic send_directed;
        logic [PW-1:0] p[NPT];
        logic [PW-1:0] v[NPT];
        // unit grid, constant and quadratic values
        for (int i = 0; i < NPT; i++) begin
            p[i] = (i - 2) <<< FRAC_BITS;
            v[i] = 32'h0001_0000;
        end
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) v[i] = ((i - 2) * (i - 2)) <<< FRAC_BITS;
        send_stencil(pack_stencil(p, v));
        // extreme values on a unit grid
        for (int i = 0; i < NPT; i++) v[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) v[i] = 32'h8000_0000;
        send_stencil(pack_stencil(p, v));
        // tightest spacing: saturation both ways
        for (int i = 0; i < NPT; i++) begin
            p[i] = i;
            v[i] = (i == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) v[i] = (i == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_stencil(pack_stencil(p, v));
        // extreme positions
        p[0] = 32'h8000_0000; p[1] = 32'h7FFF_FFFF; p[2] = 32'h0;
        p[3] = 32'hFFFF_FFFF; p[4] = 32'h0000_0001;
        for (int i = 0; i < NPT; i++) v[i] = 32'h0001_0000 * (i + 1);
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) v[i] = 32'h7FFF_FFFF;
        send_stencil(pack_stencil(p, v));
        // coinciding points: first pair, second pair, last pair, first and last point
        for (int i = 0; i < NPT; i++) p[i] = i <<< FRAC_BITS;
        p[1] = p[0];
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) p[i] = i <<< FRAC_BITS;
        p[2] = p[1];
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) p[i] = i <<< FRAC_BITS;
        p[4] = p[3];
        send_stencil(pack_stencil(p, v));
        p[4] = p[0];
        send_stencil(pack_stencil(p, v));
        // zero values, all-ones bits
        for (int i = 0; i < NPT; i++) begin
            p[i] = (i - 2) <<< FRAC_BITS;
            v[i] = 32'h0;
        end
        send_stencil(pack_stencil(p, v));
        for (int i = 0; i < NPT; i++) v[i] = 32'hFFFF_FFFF;
        send_stencil(pack_stencil(p, v));
    endtask

    logic [ORD_W-1:0] order_plan[11] = '{3'd2, 3'd4, 3'd3, 3'd0, 3'd1, 3'd5,
                                         3'd7, 3'd6, 3'd4, 3'd3, 3'd2};

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        idle_on    = 1'b1;
        sent_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset order first, then every setting in turn
        send_directed();
        for (int ph = 0; ph < 11; ph++) begin
            if (ph > 0) set_order(order_plan[ph]);
            if (ph == 1 || ph == 2) send_directed();
            // one phase runs flat out
            idle_on = (ph != 8);
            for (int k = 0; k < 165; k++) send_random();
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (LATENCY) @(posedge i_clk);

        $display("Sent %0d stencils over orders 0..7; %0d results checked, %0d with fault.",
                 sent_count, result_count, fault_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/nsd_pkg.sv
hw/rtl/nsd_div.sv
hw/rtl/nonuniform_second_derivative.sv
hw/rtl/nsd_chk.sv
tb/nsd_checker.sv
tb/testbench.sv
